FILE: src/tbb_pkg.sv
// shared types and constants for the transformed box bounds unit
// no dependencies; the rtl files refer to this package by scoped names, the testbench imports it
`default_nettype none

package tbb_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int TERM_W    = PROD_W - FRAC_BITS;
    localparam int SUM_W     = TERM_W + 2;
    localparam int NUM_ROWS  = 3;
    localparam int NUM_COLS  = 4;
    localparam int NUM_AXES  = 3;
    localparam int NUM_REGS  = 6;
    localparam int PADDR_W   = 5;
    localparam int IDX_W     = 3;
    localparam int IN_W      = NUM_ROWS * NUM_COLS * WORD_W;
    localparam int OUT_W     = 2 * NUM_ROWS * WORD_W;

    localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [IDX_W-1:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } reg_idx_t;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [TERM_W-1:0] term_t;

    // row r, column c sits at bits (r*NUM_COLS + c)*WORD_W
    typedef word_t [NUM_COLS-1:0] row_t;
    typedef row_t  [NUM_ROWS-1:0] mat_t;

    typedef struct packed {
        word_t [NUM_AXES-1:0] hi;
        word_t [NUM_AXES-1:0] lo;
    } box_t;

    typedef struct packed {
        prod_t [NUM_ROWS-1:0][NUM_AXES-1:0] lo_prod;
        prod_t [NUM_ROWS-1:0][NUM_AXES-1:0] hi_prod;
        word_t [NUM_ROWS-1:0]               offs;
    } prod_set_t;

    typedef struct packed {
        term_t [NUM_ROWS-1:0][NUM_AXES-1:0] min_term;
        term_t [NUM_ROWS-1:0][NUM_AXES-1:0] max_term;
        word_t [NUM_ROWS-1:0]               offs;
    } term_set_t;

    typedef struct packed {
        word_t [NUM_ROWS-1:0] hi;
        word_t [NUM_ROWS-1:0] lo;
    } bounds_t;

endpackage

`default_nettype wire

FILE: src/transformed_box_bounds_unit.sv
// Transformed box bounds unit: bounds of an axis-aligned box after an affine transform.
// The box corners come from six APB registers (min x/y/z at 0x00..0x08, max x/y/z at
// 0x0C..0x14). Each s_ transfer carries the upper three rows of a 4x4 matrix in Q16.16;
// each m_ transfer carries the least and greatest transformed x, y and z in Q16.16.
// The stages are a multiplier stage (18 32x32 products), a scale and min/max stage,
// and an add/saturate stage that is also the output register. Throughput is one
// transfer per cycle while m_tready is high; the multiplier stage sets the clock
// period. Each stage has its own valid bit and loads whenever it is empty or its
// successor takes its data, so s_tready stays high while a finished result waits as
// long as an earlier stage has room. A stalled receiver fills the pipe; then s_tready
// drops and nothing is lost or repeated. Reset clears all stage valid bits and sets the
// box registers to zero. Write the box registers only while the pipeline is empty.
// depends on tbb_pkg, tbb_apb_regs, tbb_mul_stage, tbb_minmax_stage, tbb_sum_stage
`default_nettype none

module transformed_box_bounds_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // fields from bit 0 up: xform_r0_c0..r0_c3, r1_c0..r1_c3, r2_c0..r2_c3
    input  wire logic [tbb_pkg::IN_W-1:0]     s_tdata,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // fields from bit 0 up: bound_x_low, bound_x_high, bound_y_low, bound_y_high,
    // bound_z_low, bound_z_high
    output logic      [tbb_pkg::OUT_W-1:0]    m_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tbb_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tbb_pkg::WORD_W-1:0]   pwdata,
    output logic      [tbb_pkg::WORD_W-1:0]   prdata,
    output logic                              pready
);

    tbb_pkg::box_t      box;
    tbb_pkg::mat_t      mat;
    tbb_pkg::prod_set_t prod_data;
    tbb_pkg::term_set_t term_data;
    tbb_pkg::bounds_t   bounds;
    logic               prod_valid;
    logic               prod_ready;
    logic               term_valid;
    logic               term_ready;

    assign mat = tbb_pkg::mat_t'(s_tdata);

    tbb_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .box     (box)
    );

    tbb_mul_stage u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .mat       (mat),
        .box       (box),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    tbb_minmax_stage u_minmax (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (term_valid),
        .out_ready (term_ready),
        .out_data  (term_data)
    );

    tbb_sum_stage u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (term_valid),
        .in_ready  (term_ready),
        .in_data   (term_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (bounds)
    );

    // low then high for each axis
    always_comb begin
        for (int r = 0; r < tbb_pkg::NUM_ROWS; r++) begin
            m_tdata[(2*r)*tbb_pkg::WORD_W +: tbb_pkg::WORD_W]   = bounds.lo[r];
            m_tdata[(2*r+1)*tbb_pkg::WORD_W +: tbb_pkg::WORD_W] = bounds.hi[r];
        end
    end

endmodule

`default_nettype wire

FILE: src/tbb_apb_regs.sv
// apb register file holding the box corners
// depends on tbb_pkg
`default_nettype none

module tbb_apb_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tbb_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tbb_pkg::WORD_W-1:0]   pwdata,
    output logic      [tbb_pkg::WORD_W-1:0]   prdata,
    output logic                              pready,
    output tbb_pkg::box_t                     box
);

    tbb_pkg::box_t     box_reg;
    tbb_pkg::box_t     box_next;
    logic [tbb_pkg::IDX_W-1:0] idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[tbb_pkg::PADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite & pready;
    assign box    = box_reg;

    always_comb begin
        box_next = box_reg;
        if (wr_en) begin
            unique case (idx)
                tbb_pkg::REG_MIN_X: box_next.lo[0] = pwdata;
                tbb_pkg::REG_MIN_Y: box_next.lo[1] = pwdata;
                tbb_pkg::REG_MIN_Z: box_next.lo[2] = pwdata;
                tbb_pkg::REG_MAX_X: box_next.hi[0] = pwdata;
                tbb_pkg::REG_MAX_Y: box_next.hi[1] = pwdata;
                tbb_pkg::REG_MAX_Z: box_next.hi[2] = pwdata;
                default:            box_next = box_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            tbb_pkg::REG_MIN_X: prdata = box_reg.lo[0];
            tbb_pkg::REG_MIN_Y: prdata = box_reg.lo[1];
            tbb_pkg::REG_MIN_Z: prdata = box_reg.lo[2];
            tbb_pkg::REG_MAX_X: prdata = box_reg.hi[0];
            tbb_pkg::REG_MAX_Y: prdata = box_reg.hi[1];
            tbb_pkg::REG_MAX_Z: prdata = box_reg.hi[2];
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg <= '0;
        end else begin
            box_reg <= box_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/tbb_mul_stage.sv
// pipeline stage 1: gain times corner products for both corner values per axis
// depends on tbb_pkg
`default_nettype none

module tbb_mul_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire tbb_pkg::mat_t mat,
    input  wire tbb_pkg::box_t box,
    output logic               out_valid,
    input  wire logic          out_ready,
    output tbb_pkg::prod_set_t out_data
);

    logic               valid_reg;
    logic               valid_next;
    tbb_pkg::prod_set_t data_reg;
    tbb_pkg::prod_set_t data_next;
    logic               load;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // one 32x32 signed multiplier per gain and corner value
    always_comb begin
        for (int r = 0; r < tbb_pkg::NUM_ROWS; r++) begin
            for (int a = 0; a < tbb_pkg::NUM_AXES; a++) begin
                data_next.lo_prod[r][a] = tbb_pkg::prod_t'($signed(mat[r][a]))
                                        * tbb_pkg::prod_t'($signed(box.lo[a]));
                data_next.hi_prod[r][a] = tbb_pkg::prod_t'($signed(mat[r][a]))
                                        * tbb_pkg::prod_t'($signed(box.hi[a]));
            end
            data_next.offs[r] = mat[r][tbb_pkg::NUM_COLS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/tbb_minmax_stage.sv
// pipeline stage 2: scale products down and sort each corner pair into min and max
// depends on tbb_pkg
`default_nettype none

module tbb_minmax_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire tbb_pkg::prod_set_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output tbb_pkg::term_set_t      out_data
);

    logic               valid_reg;
    logic               valid_next;
    tbb_pkg::term_set_t data_reg;
    tbb_pkg::term_set_t data_next;
    logic               load;

    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    // dropping the low fraction bits is a floor shift; each axis term picks
    // independently, so the corner extremes are sums of per-axis extremes
    always_comb begin
        tbb_pkg::term_t t_lo;
        tbb_pkg::term_t t_hi;
        t_lo = '0;
        t_hi = '0;
        data_next.offs = in_data.offs;
        for (int r = 0; r < tbb_pkg::NUM_ROWS; r++) begin
            for (int a = 0; a < tbb_pkg::NUM_AXES; a++) begin
                t_lo = $signed(in_data.lo_prod[r][a][tbb_pkg::PROD_W-1:tbb_pkg::FRAC_BITS]);
                t_hi = $signed(in_data.hi_prod[r][a][tbb_pkg::PROD_W-1:tbb_pkg::FRAC_BITS]);
                if (t_lo < t_hi) begin
                    data_next.min_term[r][a] = t_lo;
                    data_next.max_term[r][a] = t_hi;
                end else begin
                    data_next.min_term[r][a] = t_hi;
                    data_next.max_term[r][a] = t_lo;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/tbb_sum_stage.sv
// pipeline stage 3: add terms and offset, saturate to 32 bits; this is the output register
// depends on tbb_pkg
`default_nettype none

module tbb_sum_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire tbb_pkg::term_set_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output tbb_pkg::bounds_t        out_data
);

    logic             valid_reg;
    logic             valid_next;
    tbb_pkg::bounds_t data_reg;
    tbb_pkg::bounds_t data_next;
    logic             load;

    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    function automatic tbb_pkg::word_t sat_word(input logic signed [tbb_pkg::SUM_W-1:0] s);
        logic [tbb_pkg::SUM_W-tbb_pkg::WORD_W:0] top;
        tbb_pkg::word_t                            res;
        top = s[tbb_pkg::SUM_W-1:tbb_pkg::WORD_W-1];
        if (top == '0 || top == '1) begin
            res = s[tbb_pkg::WORD_W-1:0];
        end else if (s[tbb_pkg::SUM_W-1]) begin
            res = tbb_pkg::WORD_MIN;
        end else begin
            res = tbb_pkg::WORD_MAX;
        end
        return res;
    endfunction

    always_comb begin
        logic signed [tbb_pkg::SUM_W-1:0] s_lo;
        logic signed [tbb_pkg::SUM_W-1:0] s_hi;
        logic signed [tbb_pkg::SUM_W-1:0] offs_ext;
        s_lo     = '0;
        s_hi     = '0;
        offs_ext = '0;
        for (int r = 0; r < tbb_pkg::NUM_ROWS; r++) begin
            offs_ext = tbb_pkg::SUM_W'($signed(in_data.offs[r]));
            s_lo = tbb_pkg::SUM_W'($signed(in_data.min_term[r][0]))
                 + tbb_pkg::SUM_W'($signed(in_data.min_term[r][1]))
                 + tbb_pkg::SUM_W'($signed(in_data.min_term[r][2]))
                 + offs_ext;
            s_hi = tbb_pkg::SUM_W'($signed(in_data.max_term[r][0]))
                 + tbb_pkg::SUM_W'($signed(in_data.max_term[r][1]))
                 + tbb_pkg::SUM_W'($signed(in_data.max_term[r][2]))
                 + offs_ext;
            data_next.lo[r] = sat_word(s_lo);
            data_next.hi[r] = sat_word(s_hi);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_transformed_box_bounds_unit.sv
`timescale 1ns / 100ps
// testbench for transformed_box_bounds_unit: matrix transfers with random gaps and stalls,
// bounds predicted in the bench and checked field by field; depends on tbb_pkg and the rtl

module tb_transformed_box_bounds_unit;
    import tbb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PIPE_DEPTH  = 3;
    localparam int NUM_PHASES  = 7;
    localparam int PHASE_ITEMS = 250;
    localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;
    localparam word_t ONE = 32'sh0001_0000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [IN_W-1:0]      s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [WORD_W-1:0]    pwdata   = '0;
    logic [WORD_W-1:0]    prdata;
    logic                 pready;

    // bench copy of the box registers
    word_t   box_lo [NUM_AXES];
    word_t   box_hi [NUM_AXES];
    bounds_t pending_bounds [$];
    int      fails      = 0;
    bit      tx_burst   = 1'b0;
    bit      rx_burst   = 1'b0;
    int      stall_left = 0;
    int      cycles     = 0;
    string   field_names [6] = '{"bound_x_low", "bound_x_high", "bound_y_low",
                                 "bound_y_high", "bound_z_low", "bound_z_high"};

    transformed_box_bounds_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // one transformed coordinate: floor-shifted products plus offset, saturated once
    function automatic word_t row_eval(row_t g, word_t x, word_t y, word_t z);
        longint acc;
        acc = longint'(g[3]);
        acc += (longint'(g[0]) * longint'(x)) >>> FRAC_BITS;
        acc += (longint'(g[1]) * longint'(y)) >>> FRAC_BITS;
        acc += (longint'(g[2]) * longint'(z)) >>> FRAC_BITS;
        if (acc > longint'(32'sh7FFF_FFFF))
            return WORD_MAX;
        if (acc < -longint'(64'sh8000_0000))
            return WORD_MIN;
        return word_t'(acc);
    endfunction

    function automatic bounds_t predict_bounds(mat_t m);
        bounds_t b;
        word_t   x, y, z, p;
        b = '0;
        for (int k = 0; k < 8; k++) begin
            x = (k & 1) ? box_hi[0] : box_lo[0];
            y = (k & 2) ? box_hi[1] : box_lo[1];
            z = (k & 4) ? box_hi[2] : box_lo[2];
            for (int r = 0; r < NUM_ROWS; r++) begin
                p = row_eval(m[r], x, y, z);
                if (k == 0 || p < b.lo[r])
                    b.lo[r] = p;
                if (k == 0 || p > b.hi[r])
                    b.hi[r] = p;
            end
        end
        return b;
    endfunction

    // tame values stay within +-64.0 so sums rarely saturate
    function automatic word_t rand_word(bit tame);
        if (tame)
            return word_t'($urandom_range(0, 32'h0080_0000) - 32'h0040_0000);
        case ($urandom_range(0, 7))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: return -32'sd1;
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic mat_t rand_mat(bit tame);
        mat_t m;
        for (int r = 0; r < NUM_ROWS; r++)
            for (int c = 0; c < NUM_COLS; c++)
                m[r][c] = rand_word(tame);
        return m;
    endfunction

    function automatic mat_t uniform_mat(word_t gain, word_t offs);
        mat_t m;
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < NUM_AXES; c++)
                m[r][c] = gain;
            m[r][NUM_COLS-1] = offs;
        end
        return m;
    endfunction

    function automatic mat_t identity_mat();
        mat_t m;
        m = uniform_mat('0, '0);
        for (int r = 0; r < NUM_ROWS; r++)
            m[r][r] = ONE;
        return m;
    endfunction

    task automatic send_xform(input mat_t m);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= m;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_bounds.push_back(predict_bounds(m));
    endtask

    // every transfer yields one result, so an empty queue means the pipe is empty
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_bounds.size() != 0) @(posedge aclk);
    endtask

    task automatic write_box_reg(input logic [IDX_W-1:0] idx, input word_t val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_X: box_lo[0] = val;
            REG_MIN_Y: box_lo[1] = val;
            REG_MIN_Z: box_lo[2] = val;
            REG_MAX_X: box_hi[0] = val;
            REG_MAX_Y: box_hi[1] = val;
            REG_MAX_Z: box_hi[2] = val;
            default: ;
        endcase
    endtask

    task automatic set_box(input word_t lx, input word_t ly, input word_t lz,
                           input word_t hx, input word_t hy, input word_t hz);
        drain_pipe();
        write_box_reg(REG_MIN_X, lx);
        write_box_reg(REG_MIN_Y, ly);
        write_box_reg(REG_MIN_Z, lz);
        write_box_reg(REG_MAX_X, hx);
        write_box_reg(REG_MAX_Y, hy);
        write_box_reg(REG_MAX_Z, hz);
    endtask

    // zero box after reset: every bound equals the row offset
    task automatic test_reset_box();
        for (int i = 0; i < 3; i++)
            send_xform(rand_mat(1'b0));
    endtask

    // odd fractions on the corners exercise the floor of negative products
    task automatic test_rounding_and_saturation();
        set_box(32'shFFFE_8001, 32'sh0000_0001, 32'shFFFF_FFFF,
                32'sh0001_7FFF, 32'sh0002_8003, 32'sh0000_C001);
        send_xform(identity_mat());
        send_xform(uniform_mat('0, WORD_MAX));
        send_xform(uniform_mat(-32'sd1, '0));
        send_xform(uniform_mat(-ONE, WORD_MIN));
        send_xform(uniform_mat(ONE, WORD_MAX));
        send_xform(rand_mat(1'b1));
    endtask

    task automatic test_extreme_box();
        set_box(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX);
        send_xform(uniform_mat(WORD_MAX, WORD_MAX));
        send_xform(uniform_mat(WORD_MIN, WORD_MIN));
        send_xform(uniform_mat(WORD_MIN, WORD_MAX));
        send_xform(identity_mat());
        send_xform(uniform_mat(-32'sd1, '0));
        send_xform(rand_mat(1'b0));
        // degenerate box at the most negative corner
        set_box(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        send_xform(uniform_mat(WORD_MIN, '0));
    endtask

    // min above max on every axis: corners still come from both values
    task automatic test_inverted_box();
        set_box(32'sh0002_0000, 32'sh0003_0000, 32'shFFFF_0000,
                32'shFFFD_0000, 32'shFFFF_8000, 32'shFFFC_0000);
        send_xform(identity_mat());
        send_xform(rand_mat(1'b1));
        send_xform(rand_mat(1'b1));
    endtask

    task automatic test_spare_index();
        drain_pipe();
        write_box_reg(IDX_SPARE_LO, word_t'($urandom));
        write_box_reg(IDX_SPARE_HI, word_t'($urandom));
        send_xform(rand_mat(1'b1));
        send_xform(rand_mat(1'b1));
    endtask

    task automatic test_back_to_back();
        tx_burst = 1'b1;
        rx_burst <= 1'b1;
        for (int i = 0; i < 5; i++)
            send_xform(rand_mat(1'b1));
        tx_burst = 1'b0;
        rx_burst <= 1'b0;
    endtask

    task automatic test_random_phases();
        bit box_tame;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            box_tame = (ph % 3) != 2;
            set_box(rand_word(box_tame), rand_word(box_tame), rand_word(box_tame),
                    rand_word(box_tame), rand_word(box_tame), rand_word(box_tame));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 31) == 0)
                    tx_burst = ~tx_burst;
                if ($urandom_range(0, 31) == 0)
                    rx_burst <= ~rx_burst;
                send_xform(rand_mat($urandom_range(0, 9) < 7));
            end
        end
        tx_burst = 1'b0;
        rx_burst <= 1'b0;
    endtask

    // result side: random stalls after each transfer unless rx_burst is set, compare with the oldest prediction
    always @(posedge aclk) begin : result_check
        bounds_t want;
        word_t   got;
        word_t   ref_val;
        int      n;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (m_tvalid && m_tready) begin
            if (pending_bounds.size() == 0) begin
                $error("result transfer with no matrix outstanding");
                fails++;
            end else begin
                want = pending_bounds.pop_front();
                for (int f = 0; f < 6; f++) begin
                    got     = m_tdata[WORD_W*f +: WORD_W];
                    ref_val = (f % 2 == 1) ? want.hi[f/2] : want.lo[f/2];
                    if (got !== ref_val) begin
                        $error("%s: expected %0d, got %0d", field_names[f], ref_val, got);
                        fails++;
                    end
                end
            end
            n = rx_burst ? 0 : $urandom_range(0, 9);
            stall_left <= n;
            m_tready   <= (n == 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin : main_seq
        for (int a = 0; a < NUM_AXES; a++) begin
            box_lo[a] = '0;
            box_hi[a] = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_box();
        test_rounding_and_saturation();
        test_extreme_box();
        test_inverted_box();
        test_spare_index();
        test_back_to_back();
        test_random_phases();
        drain_pipe();
        repeat (PIPE_DEPTH + 8) @(posedge aclk);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: transformed_box_bounds_unit.f
src/tbb_pkg.sv
src/tbb_apb_regs.sv
src/tbb_mul_stage.sv
src/tbb_minmax_stage.sv
src/tbb_sum_stage.sv
src/transformed_box_bounds_unit.sv
tb/tb_transformed_box_bounds_unit.sv
